### hdl/indexed_list_insert_erase_top_macros.svh
// Assertion macros for the indexed list block checker.
// Used by ilie_checker.sv; expects clk and rst_n in the including scope.
`ifndef INDEXED_LIST_INSERT_ERASE_TOP_MACROS_SVH
`define INDEXED_LIST_INSERT_ERASE_TOP_MACROS_SVH

// same-cycle implication
`define ILIE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ilie: same-cycle check failed");

// next-cycle implication
`define ILIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ilie: next-cycle check failed");

`endif

### hdl/ilie_pkg.sv
// Package for the indexed list block: sizes, operation and status codes,
// and the control structs shared by the cells, the control unit and the top.
package ilie_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int KIND_W = 4;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         addr_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 4'd0,
    KIND_INSERT = 4'd1,
    KIND_ERASE  = 4'd2,
    KIND_PUSH   = 4'd3,
    KIND_POP    = 4'd4,
    KIND_CLEAR  = 4'd5,
    KIND_RESIZE = 4'd6,
    KIND_ASSIGN = 4'd7,
    KIND_FRONT  = 4'd8,
    KIND_BACK   = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_ERA,
    CELL_FILL
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    cnt_t     lo;
    cnt_t     hi;
    word_t    value;
  } cell_ctl_t;

  typedef struct packed {
    status_t status;
    cnt_t    count;
    logic    rd_en;
    addr_t   rd_addr;
  } ctrl_resp_t;

endpackage

### hdl/ilie_in_if.sv
// Input channel of the indexed list block: valid/ready plus one operation.
// Depends on ilie_pkg.
interface ilie_in_if;
  import ilie_pkg::*;

  logic  valid;
  logic  ready;
  logic  [KIND_W-1:0] kind;
  cnt_t  index;
  word_t value;

  modport source (output valid, output kind, output index, output value, input ready);
  modport sink   (input valid, input kind, input index, input value, output ready);
  modport mon    (input valid, input kind, input index, input value, input ready);
endinterface

### hdl/ilie_out_if.sv
// Result channel of the indexed list block: valid/ready plus one result.
// Depends on ilie_pkg.
interface ilie_out_if;
  import ilie_pkg::*;

  logic  valid;
  logic  ready;
  word_t read_value;
  logic  [1:0] status;
  cnt_t  count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink   (input valid, input read_value, input status, input count, output ready);
  modport mon    (input valid, input read_value, input status, input count, input ready);
endinterface

### hdl/ilie_cell.sv
// One storage cell of the list chain: holds a word, loads the operation
// value or the word of its left or right neighbor. Depends on ilie_pkg.
module ilie_cell (
  input  logic              clk,
  input  ilie_pkg::cell_ctl_t ctl,
  input  ilie_pkg::addr_t   pos,
  input  ilie_pkg::word_t   left_word,
  input  ilie_pkg::word_t   right_word,
  output ilie_pkg::word_t   word
);
  import ilie_pkg::*;

  word_t word_r;
  word_t word_nxt;
  cnt_t  p;

  assign p = CNT_W'(pos);

  always_comb begin
    word_nxt = word_r;
    case (ctl.op)
      CELL_INS: begin
        if (p == ctl.lo) begin
          word_nxt = ctl.value;
        end else if (p > ctl.lo && p <= ctl.hi) begin
          word_nxt = left_word;
        end
      end
      CELL_ERA: begin
        if (p >= ctl.lo && (p + CNT_W'(1)) < ctl.hi) begin
          word_nxt = right_word;
        end
      end
      CELL_FILL: begin
        if (p >= ctl.lo && p < ctl.hi) begin
          word_nxt = ctl.value;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;
endmodule

### hdl/ilie_ctrl.sv
// Control unit of the indexed list: entry count register, operation decode,
// status, and the broadcast control for the cell chain. Depends on ilie_pkg.
module ilie_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  logic [ilie_pkg::KIND_W-1:0] kind,
  input  ilie_pkg::cnt_t         index,
  input  ilie_pkg::word_t        value,
  output ilie_pkg::cell_ctl_t    ctl,
  output ilie_pkg::ctrl_resp_t   resp
);
  import ilie_pkg::*;

  cnt_t       entry_count_r;
  cnt_t       entry_count_nxt;
  cell_ctl_t  ctl_c;
  ctrl_resp_t resp_c;
  cnt_t       c;

  assign c = entry_count_r;

  always_comb begin
    ctl_c.op        = CELL_HOLD;
    ctl_c.lo        = '0;
    ctl_c.hi        = '0;
    ctl_c.value     = value;
    resp_c.status   = ST_OK;
    resp_c.count    = c;
    resp_c.rd_en    = 1'b0;
    resp_c.rd_addr  = '0;
    case (kind)
      KIND_READ: begin
        if (index >= c) begin
          resp_c.status = ST_RANGE;
        end else begin
          resp_c.rd_en   = 1'b1;
          resp_c.rd_addr = index[IDX_W-1:0];
        end
      end
      KIND_INSERT: begin
        if (index > c) begin
          resp_c.status = ST_RANGE;
        end else if (c == DEPTH_C) begin
          resp_c.status = ST_FULL;
        end else begin
          ctl_c.op     = CELL_INS;
          ctl_c.lo     = index;
          ctl_c.hi     = c;
          resp_c.count = c + CNT_W'(1);
        end
      end
      KIND_ERASE: begin
        if (index >= c) begin
          resp_c.status = ST_RANGE;
        end else begin
          ctl_c.op     = CELL_ERA;
          ctl_c.lo     = index;
          ctl_c.hi     = c;
          resp_c.count = c - CNT_W'(1);
        end
      end
      KIND_PUSH: begin
        if (c == DEPTH_C) begin
          resp_c.status = ST_FULL;
        end else begin
          ctl_c.op     = CELL_FILL;
          ctl_c.lo     = c;
          ctl_c.hi     = c + CNT_W'(1);
          resp_c.count = c + CNT_W'(1);
        end
      end
      KIND_POP: begin
        if (c == '0) begin
          resp_c.status = ST_EMPTY;
        end else begin
          resp_c.count = c - CNT_W'(1);
        end
      end
      KIND_CLEAR: resp_c.count = '0;
      KIND_RESIZE: begin
        if (index > DEPTH_C) begin
          resp_c.status = ST_FULL;
        end else begin
          if (index > c) begin
            ctl_c.op = CELL_FILL;
            ctl_c.lo = c;
            ctl_c.hi = index;
          end
          resp_c.count = index;
        end
      end
      KIND_ASSIGN: begin
        if (index > DEPTH_C) begin
          resp_c.status = ST_FULL;
        end else begin
          ctl_c.op     = CELL_FILL;
          ctl_c.lo     = '0;
          ctl_c.hi     = index;
          resp_c.count = index;
        end
      end
      KIND_FRONT: begin
        if (c == '0) begin
          resp_c.status = ST_RANGE;
        end else begin
          resp_c.rd_en = 1'b1;
        end
      end
      KIND_BACK: begin
        if (c == '0) begin
          resp_c.status = ST_RANGE;
        end else begin
          resp_c.rd_en   = 1'b1;
          resp_c.rd_addr = IDX_W'(c - CNT_W'(1));
        end
      end
      default: resp_c.status = ST_OK;
    endcase
    if (!fire) begin
      ctl_c.op = CELL_HOLD;
    end
  end

  assign entry_count_nxt = fire ? resp_c.count : entry_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else begin
      entry_count_r <= entry_count_nxt;
    end
  end

  assign ctl  = ctl_c;
  assign resp = resp_c;
endmodule

### hdl/indexed_list_insert_erase_top.sv
// Top level of the indexed list: control unit, chain of storage cells,
// read select and output register. Depends on ilie_pkg, ilie_in_if, ilie_out_if.
//
//   channel  | dir | payload                          | handshake
//   ---------+-----+----------------------------------+-------------
//   in_ch    | in  | kind, index, value               | valid/ready
//   out_ch   | out | read_value, status, count        | valid/ready
//
// One transfer per cycle unless the result stalls: every operation, insert
// and erase included, completes in the cycle it is accepted, since each cell
// loads from its neighbor in a single step. The result is output registered.
// Synchronous active-low reset empties the list and drops any pending result.
// A stalled result holds; a new transfer is taken in the cycle it leaves.
module indexed_list_insert_erase_top (
  input  logic        clk,
  input  logic        rst_n,
  ilie_in_if.sink     in_ch,
  ilie_out_if.source  out_ch
);
  import ilie_pkg::*;

  logic       fire;
  cell_ctl_t  ctl;
  ctrl_resp_t resp;
  word_t      words [DEPTH];
  word_t      rd_word;

  logic       out_valid_r;
  logic       out_valid_nxt;
  word_t      out_read_value_r;
  status_t    out_status_r;
  cnt_t       out_count_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  ilie_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .kind  (in_ch.kind),
    .index (in_ch.index),
    .value (in_ch.value),
    .ctl   (ctl),
    .resp  (resp)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (i == 0) begin : g_first
      assign left_w = in_ch.value;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    ilie_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (IDX_W'(i)),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i])
    );
  end

  assign rd_word = resp.rd_en ? words[resp.rd_addr] : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_read_value_r <= rd_word;
      out_status_r     <= resp.status;
      out_count_r      <= resp.count;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_read_value_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.count      = out_count_r;
endmodule

### hdl/ilie_checker.sv
// Port-level checks for the indexed list top, bound to every instance.
// Depends on ilie_pkg, the channel interfaces and the assertion macro header.
`include "indexed_list_insert_erase_top_macros.svh"

module ilie_checker (
  input logic         clk,
  input logic         rst_n,
  ilie_in_if.sink     in_ch,
  ilie_out_if.source  out_ch
);
  import ilie_pkg::*;

  `ILIE_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.count))
  `ILIE_ASSERT_NOW(a_count_cap, out_ch.valid, out_ch.count <= DEPTH_C)
  `ILIE_ASSERT_NEXT(a_clear_empties, in_ch.valid && in_ch.ready && in_ch.kind == KIND_CLEAR, out_ch.valid && out_ch.count == '0 && out_ch.status == ST_OK)
  `ILIE_ASSERT_NOW(a_empty_zero, out_ch.valid && out_ch.status == ST_EMPTY, out_ch.count == '0)
  `ILIE_ASSERT_NOW(a_err_no_data, out_ch.valid && out_ch.status != ST_OK, out_ch.read_value == '0)
endmodule

bind indexed_list_insert_erase_top ilie_checker u_ilie_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
